[hw/rtl/im2col_pkg.sv]
// ----------------------------------------------------------------------------
// im2col_pkg
// Shared types and constants for the im2col patch unroller.
// ----------------------------------------------------------------------------
package im2col_pkg;

  // Default store geometry
  localparam int MAX_PIXELS_DEF = 4096;
  localparam int WORD_BITS_DEF  = 32;

  // Fixed field widths
  localparam int PIXEL_W  = 32;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;
  localparam int ADDR_SUM_W = 18;  // chan * H * W + r * W + c never exceeds 2^18 - 1

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PW    = $clog2(Q_DEPTH);

  // Request codes
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_EMIT   = 2'd1;
  localparam logic [1:0] FUNC_REWIND = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_CHANNELS     = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [2:0] REG_KERNEL_SIZE  = 3'd3;
  localparam logic [2:0] REG_PADDING      = 3'd4;
  localparam logic [2:0] REG_STEP         = 3'd5;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [6:0] nc;
    logic [6:0] nh;
    logic [6:0] nw;
    logic [2:0] nk;
    logic [1:0] pad;
    logic [2:0] ns;
  } cfg_t;

  // Tap description for one emitted element
  typedef struct packed {
    logic [5:0] chan;
    logic [5:0] row;
    logic [5:0] col;
    logic       pad;
    logic       last;
  } emit_info_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_ADDR,
    BK_DATA
  } bk_state_t;

endpackage

[hw/rtl/im2col_cfg_regs.sv]
// ----------------------------------------------------------------------------
// im2col_cfg_regs
// APB-style register file with clamped view of the scan geometry.
// ----------------------------------------------------------------------------
module im2col_cfg_regs import im2col_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [6:0] channels_r;
  logic [6:0] image_height_r;
  logic [6:0] image_width_r;
  logic [2:0] kernel_size_r;
  logic [1:0] padding_r;
  logic [2:0] step_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_r     <= 7'd1;
      image_height_r <= 7'd8;
      image_width_r  <= 7'd8;
      kernel_size_r  <= 3'd3;
      padding_r      <= 2'd1;
      step_r         <= 3'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CHANNELS:     channels_r     <= pwdata[6:0];
        REG_IMAGE_HEIGHT: image_height_r <= pwdata[6:0];
        REG_IMAGE_WIDTH:  image_width_r  <= pwdata[6:0];
        REG_KERNEL_SIZE:  kernel_size_r  <= pwdata[2:0];
        REG_PADDING:      padding_r      <= pwdata[1:0];
        REG_STEP:         step_r         <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CHANNELS:     prdata = CFG_DW'(channels_r);
      REG_IMAGE_HEIGHT: prdata = CFG_DW'(image_height_r);
      REG_IMAGE_WIDTH:  prdata = CFG_DW'(image_width_r);
      REG_KERNEL_SIZE:  prdata = CFG_DW'(kernel_size_r);
      REG_PADDING:      prdata = CFG_DW'(padding_r);
      REG_STEP:         prdata = CFG_DW'(step_r);
      default:          prdata = '0;
    endcase
  end

  // Clamp dimensions to 1..64, kernel to 1..7, stride to 1..4
  always_comb begin
    cfg.nc  = (channels_r == 7'd0) ? 7'd1 : ((channels_r > 7'd64) ? 7'd64 : channels_r);
    cfg.nh  = (image_height_r == 7'd0) ? 7'd1 :
              ((image_height_r > 7'd64) ? 7'd64 : image_height_r);
    cfg.nw  = (image_width_r == 7'd0) ? 7'd1 :
              ((image_width_r > 7'd64) ? 7'd64 : image_width_r);
    cfg.nk  = (kernel_size_r == 3'd0) ? 3'd1 : kernel_size_r;
    cfg.pad = padding_r;
    cfg.ns  = (step_r == 3'd0) ? 3'd1 : ((step_r > 3'd4) ? 3'd4 : step_r);
  end

endmodule

[hw/rtl/im2col_front.sv]
// ----------------------------------------------------------------------------
// im2col_front
// Request decode, load counter and scan counters; posts work to the queue.
// ----------------------------------------------------------------------------
module im2col_front import im2col_pkg::*; #(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [PIXEL_W-1:0]            in_pixel,
  input  logic                          q_full,
  output logic                          q_push,
  output logic                          q_is_load,
  output logic [$clog2(MAX_PIXELS)-1:0] q_waddr,
  output logic [WORD_BITS-1:0]          q_wdata,
  output emit_info_t                    q_info
);

  localparam int AW  = $clog2(MAX_PIXELS);
  localparam int LCW = $clog2(MAX_PIXELS + 1);

  logic [LCW-1:0] load_count_r, load_count_nxt;
  logic [5:0]     chan_r, chan_nxt;
  logic [2:0]     krow_r, krow_nxt;
  logic [2:0]     kcol_r, kcol_nxt;
  logic [5:0]     orow_r, orow_nxt;
  logic [5:0]     ocol_r, ocol_nxt;

  logic       accept;
  logic       store_full;
  logic [7:0] row_s, col_s;
  logic       row_out, col_out;
  logic       cw, ch, ckc, ckr, cc;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign store_full = (load_count_r == LCW'(MAX_PIXELS));

  // Tap position, may go negative by up to the padding
  assign row_s   = 8'(krow_r) + 8'(orow_r) - 8'(cfg.pad);
  assign col_s   = 8'(kcol_r) + 8'(ocol_r) - 8'(cfg.pad);
  assign row_out = row_s[7] || (row_s[6:0] >= cfg.nh);
  assign col_out = col_s[7] || (col_s[6:0] >= cfg.nw);

  assign cw  = (7'(ocol_r) + 7'(cfg.ns)) >= cfg.nw;
  assign ch  = (7'(orow_r) + 7'(cfg.ns)) >= cfg.nh;
  assign ckc = (4'(kcol_r) + 4'd1) >= 4'(cfg.nk);
  assign ckr = (4'(krow_r) + 4'd1) >= 4'(cfg.nk);
  assign cc  = (7'(chan_r) + 7'd1) >= cfg.nc;

  assign q_is_load   = (in_func == FUNC_LOAD);
  assign q_waddr     = load_count_r[AW-1:0];
  assign q_wdata     = in_pixel[WORD_BITS-1:0];
  assign q_info.chan = chan_r;
  assign q_info.row  = row_s[5:0];
  assign q_info.col  = col_s[5:0];
  assign q_info.pad  = row_out || col_out;
  assign q_info.last = cw && ch && ckc && ckr && cc;

  always_comb begin
    load_count_nxt = load_count_r;
    chan_nxt = chan_r;
    krow_nxt = krow_r;
    kcol_nxt = kcol_r;
    orow_nxt = orow_r;
    ocol_nxt = ocol_r;
    q_push   = 1'b0;
    if (accept) begin
      unique case (in_func)
        FUNC_LOAD: begin
          // drop the word once the store is full
          if (!store_full) begin
            q_push = 1'b1;
            load_count_nxt = load_count_r + LCW'(1);
          end
        end
        FUNC_EMIT: begin
          q_push = 1'b1;
          if (!cw) begin
            ocol_nxt = ocol_r + 6'(cfg.ns);
          end else begin
            ocol_nxt = '0;
            if (!ch) begin
              orow_nxt = orow_r + 6'(cfg.ns);
            end else begin
              orow_nxt = '0;
              if (!ckc) begin
                kcol_nxt = kcol_r + 3'd1;
              end else begin
                kcol_nxt = '0;
                if (!ckr) begin
                  krow_nxt = krow_r + 3'd1;
                end else begin
                  krow_nxt = '0;
                  chan_nxt = cc ? 6'd0 : chan_r + 6'd1;
                end
              end
            end
          end
        end
        FUNC_REWIND: begin
          load_count_nxt = '0;
          chan_nxt = '0;
          krow_nxt = '0;
          kcol_nxt = '0;
          orow_nxt = '0;
          ocol_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      chan_r <= '0;
      krow_r <= '0;
      kcol_r <= '0;
      orow_r <= '0;
      ocol_r <= '0;
    end else begin
      load_count_r <= load_count_nxt;
      chan_r <= chan_nxt;
      krow_r <= krow_nxt;
      kcol_r <= kcol_nxt;
      orow_r <= orow_nxt;
      ocol_r <= ocol_nxt;
    end
  end

endmodule

[hw/rtl/im2col_queue.sv]
// ----------------------------------------------------------------------------
// im2col_queue
// Small first-in first-out queue between front and back.
// ----------------------------------------------------------------------------
module im2col_queue import im2col_pkg::*; #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              full,
  output logic              not_empty
);

  logic [DATA_W-1:0] slot_r [Q_DEPTH];
  logic [Q_PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_PW:0]     count_r;

  assign full      = (count_r == (Q_PW+1)'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (Q_PW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (Q_PW+1)'(1);
      end
    end
  end

endmodule

[hw/rtl/im2col_back.sv]
// ----------------------------------------------------------------------------
// im2col_back
// Pixel store, address arithmetic and output register.
// ----------------------------------------------------------------------------
module im2col_back import im2col_pkg::*; #(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic                          q_is_load,
  input  logic [$clog2(MAX_PIXELS)-1:0] q_waddr,
  input  logic [WORD_BITS-1:0]          q_wdata,
  input  emit_info_t                    q_info,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [PIXEL_W-1:0]            out_value,
  output logic                          out_is_padding,
  output logic                          out_last
);

  localparam int AW = $clog2(MAX_PIXELS);

  bk_state_t state_r, state_nxt;

  logic [WORD_BITS-1:0]  store [MAX_PIXELS];
  logic [WORD_BITS-1:0]  rd_data_r;
  logic [12:0]           hw_r;
  emit_info_t            info_r;
  logic [ADDR_SUM_W-1:0] prod_ch_r;
  logic [11:0]           prod_row_r;
  logic [ADDR_SUM_W-1:0] addr_sum;
  logic                  zero_r;

  logic mem_we, mem_re, latch_info, load_out;

  logic                 out_valid_r, out_valid_nxt;
  logic [PIXEL_W-1:0]   out_value_r;
  logic                 out_is_padding_r;
  logic                 out_last_r;

  assign addr_sum = prod_ch_r + ADDR_SUM_W'(prod_row_r) + ADDR_SUM_W'(info_r.col);

  always_comb begin
    state_nxt  = state_r;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    latch_info = 1'b0;
    load_out   = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_is_load) begin
            mem_we = 1'b1;
          end else begin
            latch_info = 1'b1;
            state_nxt  = BK_MUL;
          end
        end
      end
      BK_MUL: begin
        state_nxt = BK_ADDR;
      end
      BK_ADDR: begin
        mem_re    = 1'b1;
        state_nxt = BK_DATA;
      end
      BK_DATA: begin
        // hold the read word until the output register frees
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[q_waddr] <= q_wdata;
    end
    if (mem_re) begin
      rd_data_r <= store[addr_sum[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    hw_r <= 13'(cfg.nh * cfg.nw);
    if (latch_info) begin
      info_r <= q_info;
    end
    if (state_r == BK_MUL) begin
      prod_ch_r  <= ADDR_SUM_W'(info_r.chan * hw_r);
      prod_row_r <= 12'(info_r.row * cfg.nw[5:0]) + (cfg.nw[6] ? {info_r.row, 6'd0} : 12'd0);
    end
    if (state_r == BK_ADDR) begin
      zero_r <= info_r.pad || (addr_sum >= ADDR_SUM_W'(MAX_PIXELS));
    end
    if (load_out) begin
      out_value_r      <= zero_r ? '0 : PIXEL_W'(rd_data_r);
      out_is_padding_r <= info_r.pad;
      out_last_r       <= info_r.last;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_is_padding = out_is_padding_r;
  assign out_last       = out_last_r;

endmodule

[hw/rtl/im2col_patch_unroller_unit.sv]
// ----------------------------------------------------------------------------
// im2col_patch_unroller_unit
// Loads an image into a pixel store and emits the unrolled column matrix.
// ----------------------------------------------------------------------------
//  port group   direction  transfer when
//  in_*         input      in_valid && in_ready
//  out_*        output     out_valid && out_ready
//  psel/...     config     psel && penable && pwrite (pready tied high)
//
//  The front takes one request a cycle while the four-entry queue has room.
//  An emit goes through the back in steps (pop, multiply, store read,
//  output load), with a registered store read; the back pops no new entry
//  until the emit is through.
//  Reset clears counters, queue and output valid; store contents persist.
//  A stalled output holds its element and the back stops, the front keeps
//  taking requests until the queue fills.
// ----------------------------------------------------------------------------
module im2col_patch_unroller_unit import im2col_pkg::*; #(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [PIXEL_W-1:0] in_pixel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIXEL_W-1:0] out_value,
  output logic               out_is_padding,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready
);

  localparam int AW  = $clog2(MAX_PIXELS);
  localparam int Q_W = 1 + AW + WORD_BITS + $bits(emit_info_t);

  cfg_t cfg;

  logic                 f_push, f_is_load;
  logic [AW-1:0]        f_waddr;
  logic [WORD_BITS-1:0] f_wdata;
  emit_info_t           f_info;

  logic                 q_full, q_not_empty, q_pop;
  logic [Q_W-1:0]       q_head;
  logic                 b_is_load;
  logic [AW-1:0]        b_waddr;
  logic [WORD_BITS-1:0] b_wdata;
  emit_info_t           b_info;

  assign {b_is_load, b_waddr, b_wdata, b_info} = q_head;

  im2col_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  im2col_front #(
    .MAX_PIXELS (MAX_PIXELS),
    .WORD_BITS  (WORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .in_pixel  (in_pixel),
    .q_full    (q_full),
    .q_push    (f_push),
    .q_is_load (f_is_load),
    .q_waddr   (f_waddr),
    .q_wdata   (f_wdata),
    .q_info    (f_info)
  );

  im2col_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_is_load, f_waddr, f_wdata, f_info}),
    .pop       (q_pop),
    .pop_data  (q_head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  im2col_back #(
    .MAX_PIXELS (MAX_PIXELS),
    .WORD_BITS  (WORD_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_valid        (q_not_empty),
    .q_pop          (q_pop),
    .q_is_load      (b_is_load),
    .q_waddr        (b_waddr),
    .q_wdata        (b_wdata),
    .q_info         (b_info),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_is_padding (out_is_padding),
    .out_last       (out_last)
  );

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the im2col patch unroller unit.
// Loads images, writes geometry over the register port and runs the scan
// through full matrices, clamped registers, taps past the end of the store
// and reconfiguration in mid-scan, then random traffic. Every emitted element
// is compared with a behavioural copy of the scan that runs alongside the
// design.
// ----------------------------------------------------------------------------
module tb;
  import im2col_pkg::*;

  localparam int         STORE_DEPTH    = MAX_PIXELS_DEF;
  localparam int         SETTLE_CYCLES  = 16;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] FUNC_SPARE     = 2'd3;

  typedef struct packed {
    logic [PIXEL_W-1:0] value;
    logic               is_padding;
    logic               last;
  } col_elem_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_func = FUNC_LOAD;
  logic [PIXEL_W-1:0] in_pixel = '0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic [PIXEL_W-1:0] out_value;
  logic               out_is_padding;
  logic               out_last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [CFG_AW-1:0]  paddr = '0;
  logic [CFG_DW-1:0]  pwdata = '0;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;

  // scan copy: image store, load pointer, counters and raw registers
  logic [PIXEL_W-1:0] img_store [STORE_DEPTH];
  int                 n_loaded = 0;
  int                 written_top = 0;
  int                 ch_i = 0, kr_i = 0, kc_i = 0, orow_i = 0, ocol_i = 0;
  logic [6:0]         r_chan = 7'd1, r_height = 7'd8, r_width = 7'd8;
  logic [2:0]         r_ksize = 3'd3, r_step = 3'd1;
  logic [1:0]         r_pad = 2'd1;
  bit                 last_predicted = 1'b0;

  col_elem_t          pending_elems [$];
  int                 errors = 0;
  int                 idle_cycles = 0;
  bit                 calm = 1'b0;

  im2col_patch_unroller_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_is_padding (out_is_padding),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int clamp_to(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Store address of the next tap, or -1 when it falls in the padding
  function automatic int tap_addr();
    int nh, nw, pd, r, c;
    nh = clamp_to(r_height, 1, 64);
    nw = clamp_to(r_width, 1, 64);
    pd = r_pad;
    r = kr_i + orow_i - pd;
    c = kc_i + ocol_i - pd;
    if (r < 0 || c < 0 || r >= nh || c >= nw) return -1;
    return ch_i * nh * nw + r * nw + c;
  endfunction

  function automatic bit tap_unwritten();
    int a;
    a = tap_addr();
    return (a >= written_top && a < STORE_DEPTH);
  endfunction

  // Advance the scan copy by one accepted request and queue any element it yields
  function automatic void unroll_step(logic [1:0] f, logic [PIXEL_W-1:0] px);
    int        nc, nh, nw, nk, ns, addr;
    bit        wrap_c, wrap_r, wrap_kc, wrap_kr, wrap_ch;
    col_elem_t e;
    case (f)
      FUNC_LOAD: begin
        if (n_loaded < STORE_DEPTH) begin
          img_store[n_loaded] = px;
          n_loaded++;
          if (n_loaded > written_top) written_top = n_loaded;
        end
      end
      FUNC_REWIND: begin
        n_loaded = 0;
        ch_i = 0; kr_i = 0; kc_i = 0; orow_i = 0; ocol_i = 0;
      end
      FUNC_EMIT: begin
        nc = clamp_to(r_chan, 1, 64);
        nh = clamp_to(r_height, 1, 64);
        nw = clamp_to(r_width, 1, 64);
        nk = clamp_to(r_ksize, 1, 7);
        ns = clamp_to(r_step, 1, 4);
        addr = tap_addr();
        e = '0;
        // taps past the end of the store read as zero
        if (addr < 0) begin
          e.is_padding = 1'b1;
        end else if (addr < STORE_DEPTH) begin
          e.value = img_store[addr];
        end
        wrap_c  = (ocol_i + ns >= nw);
        wrap_r  = (orow_i + ns >= nh);
        wrap_kc = (kc_i + 1 >= nk);
        wrap_kr = (kr_i + 1 >= nk);
        wrap_ch = (ch_i + 1 >= nc);
        e.last = wrap_c && wrap_r && wrap_kc && wrap_kr && wrap_ch;
        pending_elems.push_back(e);
        last_predicted = e.last;
        if (!wrap_c) begin
          ocol_i += ns;
        end else begin
          ocol_i = 0;
          if (!wrap_r) begin
            orow_i += ns;
          end else begin
            orow_i = 0;
            if (!wrap_kc) begin
              kc_i++;
            end else begin
              kc_i = 0;
              if (!wrap_kr) begin
                kr_i++;
              end else begin
                kr_i = 0;
                ch_i = wrap_ch ? 0 : ch_i + 1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_req(logic [1:0] f, logic [PIXEL_W-1:0] px);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_pixel <= px;
    do @(posedge clk); while (!in_ready);
    unroll_step(f, px);
  endtask

  // Emit, or load instead while the next tap would read a store entry never written
  task automatic send_emit_or_load();
    if (tap_unwritten()) send_req(FUNC_LOAD, $urandom());
    else send_req(FUNC_EMIT, $urandom());
  endtask

  // Hold off the sender until every element is back and the back end is quiet
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CHANNELS:     r_chan   = val[6:0];
      REG_IMAGE_HEIGHT: r_height = val[6:0];
      REG_IMAGE_WIDTH:  r_width  = val[6:0];
      REG_KERNEL_SIZE:  r_ksize  = val[2:0];
      REG_PADDING:      r_pad    = val[1:0];
      REG_STEP:         r_step   = val[2:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_geometry(int nc, int nh, int nw, int k, int pd, int st);
    write_reg(REG_CHANNELS, nc);
    write_reg(REG_IMAGE_HEIGHT, nh);
    write_reg(REG_IMAGE_WIDTH, nw);
    write_reg(REG_KERNEL_SIZE, k);
    write_reg(REG_PADDING, pd);
    write_reg(REG_STEP, st);
  endtask

  task automatic test_reset_config();
    // one 8x8 channel, 3x3 kernel, border 1, stride 1
    repeat (64) send_req(FUNC_LOAD, $urandom());
    repeat (20) send_req(FUNC_EMIT, $urandom());
    wait_idle();
  endtask

  task automatic test_small_matrix();
    // 2x2 image, 2x2 kernel, border 1: sixteen elements, then wrap
    set_geometry(1, 2, 2, 2, 1, 1);
    send_req(FUNC_REWIND, 32'hFFFF_FFFF);
    send_req(FUNC_LOAD, 32'h0000_0000);
    send_req(FUNC_LOAD, 32'hFFFF_FFFF);
    send_req(FUNC_LOAD, 32'hA5A5_A5A5);
    send_req(FUNC_LOAD, 32'h5A5A_5A5A);
    send_req(FUNC_SPARE, 32'hDEAD_BEEF);
    repeat (17) send_req(FUNC_EMIT, $urandom());
    send_req(FUNC_REWIND, 32'h0);
    repeat (2) send_req(FUNC_EMIT, 32'h0);
    wait_idle();
  endtask

  task automatic test_beyond_store();
    // carry channel 1 into the largest image: its taps lie past the end of the store
    set_geometry(2, 1, 1, 1, 0, 1);
    send_req(FUNC_REWIND, 32'h0);
    send_req(FUNC_EMIT, $urandom());
    wait_idle();
    set_geometry(64, 64, 64, 1, 0, 4);
    repeat (6) send_req(FUNC_EMIT, $urandom());
    wait_idle();
  endtask

  task automatic test_clamped_registers();
    set_geometry(0, 127, 127, 0, 3, 0);
    send_req(FUNC_REWIND, 32'h0);
    repeat (12) send_req(FUNC_EMIT, $urandom());
    wait_idle();
    set_geometry(127, 0, 0, 7, 0, 7);
    send_req(FUNC_REWIND, 32'h0);
    repeat (52) send_req(FUNC_EMIT, $urandom());
    wait_idle();
    // 64 single-pixel channels with stride 5: 64 elements, then wrap
    set_geometry(127, 1, 1, 0, 0, 5);
    send_req(FUNC_REWIND, 32'h0);
    repeat (66) send_req(FUNC_EMIT, $urandom());
    wait_idle();
  endtask

  task automatic test_reconfig_midscan();
    set_geometry(2, 4, 4, 3, 1, 1);
    send_req(FUNC_REWIND, 32'h0);
    repeat (32) send_req(FUNC_LOAD, $urandom());
    repeat (37) send_req(FUNC_EMIT, $urandom());
    wait_idle();
    // shrink width and kernel below the live counters
    set_geometry(2, 4, 1, 2, 1, 1);
    repeat (20) send_req(FUNC_EMIT, $urandom());
    wait_idle();
    write_reg(REG_CHANNELS, 1);
    repeat (20) send_req(FUNC_EMIT, $urandom());
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int         phase, n, n_load, n_lim;
    logic [1:0] f;
    for (phase = 0; phase < 10; phase++) begin
      wait_idle();
      calm = (phase == 5);
      if (phase == 0) begin
        set_geometry(64, 64, 64, 7, 3, 4);
      end else if (phase == 1) begin
        set_geometry(1, 1, 1, 1, 0, 1);
      end else begin
        set_geometry(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 2),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 4),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 4),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 3),
                     $urandom_range(0, 3), $urandom_range(0, 7));
      end
      // most phases restart cleanly, the rest carry the old counters on
      if ($urandom_range(0, 3) != 0) send_req(FUNC_REWIND, $urandom());
      n_load = $urandom_range(0, 8);
      repeat (n_load) send_req(FUNC_LOAD, $urandom());
      last_predicted = 1'b0;
      n_lim = calm ? 48 : 12;
      for (n = 0; n < n_lim && (calm || !last_predicted); n++) begin
        if ($urandom_range(0, 99) < 8) begin
          f = 2'($urandom_range(0, 3));
          if (f == FUNC_EMIT) send_emit_or_load();
          else send_req(f, $urandom());
        end else begin
          send_emit_or_load();
        end
      end
      repeat (3) send_emit_or_load();
      if (phase % 3 == 0) wait_idle();
    end
    calm = 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 6);
  end

  always @(posedge clk) begin
    col_elem_t exp_e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_elems.size() == 0) begin
        $error("unexpected result: value %h is_padding %b last %b",
               out_value, out_is_padding, out_last);
        errors++;
      end else begin
        exp_e = pending_elems.pop_front();
        if (out_value !== exp_e.value) begin
          $error("value: expected %h, got %h", exp_e.value, out_value);
          errors++;
        end
        if (out_is_padding !== exp_e.is_padding) begin
          $error("is_padding: expected %b, got %b", exp_e.is_padding, out_is_padding);
          errors++;
        end
        if (out_last !== exp_e.last) begin
          $error("last: expected %b, got %b", exp_e.last, out_last);
          errors++;
        end
      end
    end
  end

  // Count cycles with no transfer anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_config();
    test_small_matrix();
    test_beyond_store();
    test_clamped_registers();
    test_reconfig_midscan();
    test_random_traffic();
    wait_idle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
